>>> sv/owmbg_pkg.sv
// Shared types, codes and timing constants for the two-segment 1-Wire master.
package owmbg_pkg;

  localparam int MV_W        = 13;
  localparam int SAMPLE_BITS = 13;
  localparam int TICK_W      = 9;

  // Sense samples keep only the low SAMPLE_BITS bits of each field.
  localparam logic [MV_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= MV_W) ? {MV_W{1'b1}} : MV_W'((1 << SAMPLE_BITS) - 1);

  localparam logic [TICK_W-1:0] SAFE_GAP     = TICK_W'(10);
  localparam logic [TICK_W-1:0] STUCK_TICK   = TICK_W'(3);
  localparam logic [TICK_W:0]   RST_PULL_LEN = (TICK_W+1)'(480);
  localparam logic [TICK_W:0]   PULL_ONE_LEN = (TICK_W+1)'(6);
  localparam logic [TICK_W:0]   PULL_ZERO_LEN = (TICK_W+1)'(60);
  localparam logic [TICK_W:0]   REC_ONE_LEN  = (TICK_W+1)'(64);
  localparam logic [TICK_W:0]   REC_ZERO_LEN = (TICK_W+1)'(10);
  localparam logic [TICK_W:0]   RST_WAIT_LEN = (TICK_W+1)'(15);
  localparam logic [TICK_W:0]   RST_WIN_LEN  = (TICK_W+1)'(240);

  localparam logic [MV_W-1:0] LINE_LOW_RST = MV_W'(800);
  localparam logic [MV_W-1:0] SHORT_RST    = MV_W'(1500);
  localparam logic [MV_W-1:0] OVERVOLT_RST = MV_W'(5500);

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_RESET = 2'd1,
    ACT_BIT   = 2'd2,
    ACT_BYTE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FAULTED = 3'd1,
    ST_UNSAFE  = 3'd2,
    ST_STUCK   = 3'd3,
    ST_BUSY    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_PRE_SAFE  = 4'd1,
    PH_PULL      = 4'd2,
    PH_RST_WAIT  = 4'd3,
    PH_RST_WIN   = 4'd4,
    PH_RECOVER   = 4'd5,
    PH_POST_SAFE = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    CFG_LINE_LOW = 2'd0,
    CFG_SHORT    = 2'd1,
    CFG_OVERVOLT = 2'd2
  } cfg_idx_t;

  // Result word, highest bit first.
  typedef struct packed {
    logic       pad;
    logic       pad2;
    logic       pad3;
    logic       pad4;
    logic       pad5;
    logic       pad6;
    logic       pad7;
    logic       fault_latched;
    logic       presence;
    status_t    status;
    logic       done_res;
    logic       busy_res;
    logic       pull_downstream;
    logic       pull_upstream;
  } res_t;

endpackage

>>> sv/onewire_master_with_bus_guard_top.sv
// Two-segment 1-Wire master with bus safety checks, stepped by tick words.
// A result word is registered into the output register, or into the skid entry while out_ stalls.
// Throughput: one word per cycle; a two-entry output buffer keeps in_tready high
// while one result waits, so input stalls only when both entries are full.
// Reset (rst_n low, synchronous) returns the sequencer to idle, clears the stuck
// fault and both output entries, and loads the default voltage thresholds.
module onewire_master_with_bus_guard_top
  import owmbg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // port[0], value[8:1], upstream_mv[21:9], downstream_mv[34:22], zeros[39:35]
  input  logic [39:0] in_tdata,
  // action[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pull_upstream[0], pull_downstream[1], busy_res[2], done_res[3], status[6:4],
  // presence[7], fault_latched[8], zeros[15:9]
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);

  logic [MV_W-1:0] line_low_r, short_r, overvolt_r;

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic              port_r, port_nxt;
  action_t           kind_r, kind_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [3:0]        bits_r, bits_nxt;
  logic              first_bad_r, first_bad_nxt;
  logic              pres_seen_r, pres_seen_nxt;
  logic              stuck_r, stuck_nxt;

  res_t res;
  res_t out_d_r, sk_d_r;
  logic out_v_r, sk_v_r;

  action_t         act;
  logic            cmd_port;
  logic [7:0]      cmd_value;
  logic [MV_W-1:0] up_mv, down_mv, sense;
  logic            push, pop;
  logic            drive, done, pres, sense_bad;
  status_t         status;
  logic [TICK_W:0] tick_inc, pull_len, rec_len;

  assign act       = action_t'(in_tuser);
  assign cmd_port  = in_tdata[0];
  assign cmd_value = in_tdata[8:1];
  assign up_mv     = in_tdata[21:9] & SAMPLE_MASK;
  assign down_mv   = in_tdata[34:22] & SAMPLE_MASK;
  assign sense     = port_r ? down_mv : up_mv;
  assign sense_bad = (sense < short_r) || (sense > overvolt_r);
  assign tick_inc  = {1'b0, tick_r} + (TICK_W+1)'(1);
  assign pull_len  = (kind_r == ACT_RESET) ? RST_PULL_LEN :
                     (shift_r[0] ? PULL_ONE_LEN : PULL_ZERO_LEN);
  assign rec_len   = shift_r[0] ? REC_ONE_LEN : REC_ZERO_LEN;

  assign in_tready = ~sk_v_r;
  assign push      = in_tvalid & in_tready;
  assign pop       = out_v_r & out_tready;

  // Next state of the sequencer for the word at the input.
  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    port_nxt      = port_r;
    kind_nxt      = kind_r;
    shift_nxt     = shift_r;
    bits_nxt      = bits_r;
    first_bad_nxt = first_bad_r;
    pres_seen_nxt = pres_seen_r;
    stuck_nxt     = stuck_r;
    drive         = 1'b0;
    done          = 1'b0;
    pres          = 1'b0;
    status        = ST_OK;
    if (act != ACT_TICK) begin
      done = 1'b1;
      if (phase_r != PH_IDLE) begin
        status = ST_BUSY;
      end else if (stuck_r) begin
        status = ST_FAULTED;
      end else begin
        done          = 1'b0;
        port_nxt      = cmd_port;
        kind_nxt      = act;
        shift_nxt     = (act == ACT_BIT) ? {7'd0, cmd_value[0]} : cmd_value;
        bits_nxt      = (act == ACT_BYTE) ? 4'd8 : 4'd1;
        pres_seen_nxt = 1'b0;
        first_bad_nxt = 1'b0;
        tick_nxt      = '0;
        phase_nxt     = PH_PRE_SAFE;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
        end
        PH_PRE_SAFE, PH_POST_SAFE: begin
          if (tick_r == '0) begin
            first_bad_nxt = sense_bad;
            tick_nxt      = TICK_W'(1);
          end else if (tick_r < SAFE_GAP) begin
            tick_nxt = tick_inc[TICK_W-1:0];
          end else begin
            tick_nxt = '0;
            if (first_bad_r || sense_bad) begin
              done      = 1'b1;
              status    = ST_UNSAFE;
              phase_nxt = PH_IDLE;
            end else if (phase_r == PH_PRE_SAFE) begin
              phase_nxt = PH_PULL;
            end else begin
              shift_nxt = {1'b0, shift_r[7:1]};
              bits_nxt  = bits_r - 4'd1;
              if (bits_r == 4'd1) begin
                done      = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_PRE_SAFE;
              end
            end
          end
        end
        PH_PULL: begin
          drive = 1'b1;
          if (tick_r == STUCK_TICK && sense > line_low_r) begin
            // Line did not follow the pull: release and latch for good.
            drive     = 1'b0;
            stuck_nxt = 1'b1;
            done      = 1'b1;
            status    = ST_STUCK;
            phase_nxt = PH_IDLE;
            tick_nxt  = '0;
          end else if (tick_inc >= pull_len) begin
            tick_nxt  = '0;
            phase_nxt = (kind_r == ACT_RESET) ? PH_RST_WAIT : PH_RECOVER;
          end else begin
            tick_nxt = tick_inc[TICK_W-1:0];
          end
        end
        PH_RST_WAIT: begin
          if (tick_inc >= RST_WAIT_LEN) begin
            tick_nxt  = '0;
            phase_nxt = PH_RST_WIN;
          end else begin
            tick_nxt = tick_inc[TICK_W-1:0];
          end
        end
        PH_RST_WIN: begin
          if (tick_r[1:0] == 2'd0 && sense < line_low_r) begin
            pres_seen_nxt = 1'b1;
          end
          if (tick_inc >= RST_WIN_LEN) begin
            tick_nxt  = '0;
            done      = 1'b1;
            pres      = pres_seen_nxt;
            phase_nxt = PH_IDLE;
          end else begin
            tick_nxt = tick_inc[TICK_W-1:0];
          end
        end
        PH_RECOVER: begin
          if (tick_inc >= rec_len) begin
            tick_nxt  = '0;
            phase_nxt = PH_POST_SAFE;
          end else begin
            tick_nxt = tick_inc[TICK_W-1:0];
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
        end
      endcase
    end
  end

  always_comb begin
    res                 = '0;
    res.pull_upstream   = drive & ~port_nxt;
    res.pull_downstream = drive & port_nxt;
    res.busy_res        = (phase_nxt != PH_IDLE);
    res.done_res        = done;
    res.status          = done ? status : ST_OK;
    res.presence        = pres;
    res.fault_latched   = stuck_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_low_r <= LINE_LOW_RST;
      short_r    <= SHORT_RST;
      overvolt_r <= OVERVOLT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_LINE_LOW: line_low_r <= cfg_wdata;
        CFG_SHORT:    short_r    <= cfg_wdata;
        CFG_OVERVOLT: overvolt_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      port_r      <= 1'b0;
      kind_r      <= ACT_TICK;
      shift_r     <= '0;
      bits_r      <= '0;
      first_bad_r <= 1'b0;
      pres_seen_r <= 1'b0;
      stuck_r     <= 1'b0;
    end else if (push) begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      port_r      <= port_nxt;
      kind_r      <= kind_nxt;
      shift_r     <= shift_nxt;
      bits_r      <= bits_nxt;
      first_bad_r <= first_bad_nxt;
      pres_seen_r <= pres_seen_nxt;
      stuck_r     <= stuck_nxt;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        sk_v_r  <= push;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      out_d_r <= sk_v_r ? sk_d_r : res;
      if (push) begin
        sk_d_r <= res;
      end
    end else if (push) begin
      sk_d_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

>>> sv/owmbg_checker.sv
// Port-level checks on the 1-Wire master's result words, bound to the top level.
module owmbg_checker
  import owmbg_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  res_t w;
  logic fault_seen_r;

  assign w = out_tdata;

  // Remembers that a delivered word already showed the stuck fault.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_seen_r <= 1'b0;
    end else if (out_tvalid && out_tready && w.fault_latched) begin
      fault_seen_r <= 1'b1;
    end
  end

  a_fault_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && fault_seen_r |-> w.fault_latched)
    else $error("stuck fault cleared without reset");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !w.done_res |-> w.status == ST_OK && !w.presence)
    else $error("status or presence set without done");

  a_pull_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (w.pull_upstream || w.pull_downstream) |->
      w.busy_res && !(w.pull_upstream && w.pull_downstream))
    else $error("pull outside a running command or on both segments");

  a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && w.done_res && w.status == ST_BUSY |-> w.busy_res)
    else $error("busy refusal ended the running command");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

endmodule

bind onewire_master_with_bus_guard_top owmbg_checker u_owmbg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> dv/tb_onewire_master_with_bus_guard_top.sv
// Self-checking testbench for the two-segment 1-Wire master with bus guard.
`timescale 1ns / 1ps

module tb_onewire_master_with_bus_guard_top;
  import owmbg_pkg::*;

  localparam int PULL_RESET_TICKS   = 480;
  localparam int PULL_ONE_TICKS     = 6;
  localparam int PULL_ZERO_TICKS    = 60;
  localparam int RECOVER_ONE_TICKS  = 64;
  localparam int RECOVER_ZERO_TICKS = 10;
  localparam int SETTLE_TICKS       = 15;
  localparam int WINDOW_TICKS       = 240;
  localparam int SAFE_SECOND_TICK   = 10;
  localparam int STUCK_CHECK_TICK   = 3;
  localparam int MV_MAX             = 8191;
  localparam int SINK_HOLD_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT     = 5000;
  localparam int RANDOM_WORDS       = 1600;

  typedef struct {
    action_t     action;
    logic        port;
    logic [7:0]  value;
    logic [12:0] up_mv;
    logic [12:0] down_mv;
  } ow_item_t;

  typedef struct packed {
    logic    pull_up;
    logic    pull_down;
    logic    busy;
    logic    done;
    status_t status;
    logic    presence;
    logic    fault;
  } word_res_t;

  // A sense level forced onto the active segment at one point of a command.
  typedef struct {
    phase_t      ph;
    int          tick;
    int          bit_idx;
    logic [12:0] level;
  } pin_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = ACT_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_LINE_LOW;
  logic [12:0] cfg_wdata = '0;

  onewire_master_with_bus_guard_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predicted master state and thresholds.
  logic [12:0] th_line_low, th_short, th_over;
  phase_t      ow_phase;
  logic [8:0]  ow_ticks;
  logic        ow_port;
  action_t     ow_kind;
  logic [7:0]  ow_shift;
  logic [3:0]  ow_bits_left;
  logic        ow_first_bad;
  logic        ow_presence_seen;
  logic        ow_stuck;

  word_res_t   expected_words[$];
  pin_t        pins_q[$];
  logic        device_present = 1'b1;
  logic        calm = 1'b0;
  logic        sink_hold = 1'b0;
  int          bad_words = 0;

  function automatic logic unsafe_level(logic [12:0] mv);
    return (mv < th_short) || (mv > th_over);
  endfunction

  // Advances the predicted master by one word and returns the word it should answer.
  function automatic word_res_t advance_master(ow_item_t it);
    logic [12:0] sense;
    int          span;
    logic        drive, done, pres;
    status_t     st;
    word_res_t   r;
    drive = 1'b0;
    done  = 1'b0;
    pres  = 1'b0;
    st    = ST_OK;
    if (it.action != ACT_TICK) begin
      done = 1'b1;
      if (ow_phase != PH_IDLE) begin
        st = ST_BUSY;
      end else if (ow_stuck) begin
        st = ST_FAULTED;
      end else begin
        done             = 1'b0;
        ow_port          = it.port;
        ow_kind          = it.action;
        ow_shift         = (it.action == ACT_BIT) ? {7'd0, it.value[0]} : it.value;
        ow_bits_left     = (it.action == ACT_BYTE) ? 4'd8 : 4'd1;
        ow_presence_seen = 1'b0;
        ow_first_bad     = 1'b0;
        ow_ticks         = '0;
        ow_phase         = PH_PRE_SAFE;
      end
    end else if (ow_phase != PH_IDLE) begin
      sense = (ow_port ? it.down_mv : it.up_mv) & SAMPLE_MASK;
      case (ow_phase)
        PH_PRE_SAFE, PH_POST_SAFE: begin
          if (ow_ticks == 0) begin
            ow_first_bad = unsafe_level(sense);
            ow_ticks     = 9'd1;
          end else if (ow_ticks < SAFE_SECOND_TICK) begin
            ow_ticks = ow_ticks + 9'd1;
          end else begin
            ow_ticks = '0;
            if (ow_first_bad || unsafe_level(sense)) begin
              done     = 1'b1;
              st       = ST_UNSAFE;
              ow_phase = PH_IDLE;
            end else if (ow_phase == PH_PRE_SAFE) begin
              ow_phase = PH_PULL;
            end else begin
              ow_shift     = ow_shift >> 1;
              ow_bits_left = ow_bits_left - 4'd1;
              if (ow_bits_left == 0) begin
                done     = 1'b1;
                ow_phase = PH_IDLE;
              end else begin
                ow_phase = PH_PRE_SAFE;
              end
            end
          end
        end
        PH_PULL: begin
          drive = 1'b1;
          if (ow_kind == ACT_RESET) span = PULL_RESET_TICKS;
          else span = ow_shift[0] ? PULL_ONE_TICKS : PULL_ZERO_TICKS;
          if (ow_ticks == STUCK_CHECK_TICK && sense > th_line_low) begin
            drive    = 1'b0;
            ow_stuck = 1'b1;
            done     = 1'b1;
            st       = ST_STUCK;
            ow_phase = PH_IDLE;
            ow_ticks = '0;
          end else if (int'(ow_ticks) + 1 >= span) begin
            ow_ticks = '0;
            ow_phase = (ow_kind == ACT_RESET) ? PH_RST_WAIT : PH_RECOVER;
          end else begin
            ow_ticks = ow_ticks + 9'd1;
          end
        end
        PH_RST_WAIT: begin
          if (int'(ow_ticks) + 1 >= SETTLE_TICKS) begin
            ow_ticks = '0;
            ow_phase = PH_RST_WIN;
          end else begin
            ow_ticks = ow_ticks + 9'd1;
          end
        end
        PH_RST_WIN: begin
          if (ow_ticks[1:0] == 2'd0 && sense < th_line_low) ow_presence_seen = 1'b1;
          if (int'(ow_ticks) + 1 >= WINDOW_TICKS) begin
            ow_ticks = '0;
            done     = 1'b1;
            pres     = ow_presence_seen;
            ow_phase = PH_IDLE;
          end else begin
            ow_ticks = ow_ticks + 9'd1;
          end
        end
        PH_RECOVER: begin
          span = ow_shift[0] ? RECOVER_ONE_TICKS : RECOVER_ZERO_TICKS;
          if (int'(ow_ticks) + 1 >= span) begin
            ow_ticks = '0;
            ow_phase = PH_POST_SAFE;
          end else begin
            ow_ticks = ow_ticks + 9'd1;
          end
        end
        default: begin
          ow_phase = PH_IDLE;
          ow_ticks = '0;
        end
      endcase
    end
    r.pull_up   = drive && (ow_port == 1'b0);
    r.pull_down = drive && (ow_port == 1'b1);
    r.busy      = (ow_phase != PH_IDLE);
    r.done      = done;
    r.status    = done ? st : ST_OK;
    r.presence  = pres;
    r.fault     = ow_stuck;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // A level that fails the safety window, or any level when none can fail.
  function automatic logic [12:0] bad_level();
    if (th_short > 0 && (th_over == MV_MAX || $urandom_range(0, 1) == 0))
      return 13'($urandom_range(int'(th_short) - 1, 0));
    if (th_over < MV_MAX) return 13'($urandom_range(MV_MAX, int'(th_over) + 1));
    return 13'($urandom);
  endfunction

  // A level that lets the running command go on as a healthy bus would.
  function automatic logic [12:0] good_level();
    case (ow_phase)
      PH_PRE_SAFE, PH_POST_SAFE: begin
        if (th_short <= th_over)
          return 13'($urandom_range(int'(th_over), int'(th_short)));
        return 13'($urandom);
      end
      PH_PULL: begin
        if (ow_ticks == STUCK_CHECK_TICK) return 13'($urandom_range(int'(th_line_low), 0));
        return 13'($urandom);
      end
      PH_RST_WIN: begin
        if (device_present) return 13'($urandom);
        return 13'($urandom_range(MV_MAX, int'(th_line_low)));
      end
      default: return 13'($urandom);
    endcase
  endfunction

  function automatic logic [12:0] active_level();
    int bidx;
    bidx = (ow_kind == ACT_BYTE) ? 8 - int'(ow_bits_left) : 0;
    foreach (pins_q[i])
      if (pins_q[i].ph == ow_phase && pins_q[i].tick == int'(ow_ticks) &&
          pins_q[i].bit_idx == bidx)
        return pins_q[i].level;
    return good_level();
  endfunction

  task automatic reset_model();
    th_line_low      = 13'd800;
    th_short         = 13'd1500;
    th_over          = 13'd5500;
    ow_phase         = PH_IDLE;
    ow_ticks         = '0;
    ow_port          = 1'b0;
    ow_kind          = ACT_TICK;
    ow_shift         = '0;
    ow_bits_left     = '0;
    ow_first_bad     = 1'b0;
    ow_presence_seen = 1'b0;
    ow_stuck         = 1'b0;
  endtask

  // Offers one word and waits until the block takes it. in_tvalid is left high.
  task automatic send_word(ow_item_t it);
    int gap;
    gap = calm ? 0 : (($urandom_range(0, 9) < 6) ? 0 : idle_len());
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {5'd0, it.down_mv, it.up_mv, it.value, it.port};
    do @(posedge clk); while (!in_tready);
    expected_words.push_back(advance_master(it));
  endtask

  task automatic send_command(action_t act, logic p, logic [7:0] v);
    ow_item_t it;
    it.action  = act;
    it.port    = p;
    it.value   = v;
    it.up_mv   = 13'($urandom);
    it.down_mv = 13'($urandom);
    send_word(it);
  endtask

  task automatic send_tick();
    ow_item_t    it;
    logic [12:0] lvl;
    lvl        = active_level();
    it.action  = ACT_TICK;
    it.port    = 1'($urandom);
    it.value   = 8'($urandom);
    it.up_mv   = 13'($urandom);
    it.down_mv = 13'($urandom);
    if (ow_phase != PH_IDLE) begin
      if (ow_port) it.down_mv = lvl;
      else it.up_mv = lvl;
    end
    send_word(it);
  endtask

  task automatic finish_command();
    while (ow_phase != PH_IDLE) send_tick();
  endtask

  task automatic pin_level(phase_t ph, int tick, int bit_idx, logic [12:0] level);
    pin_t p;
    p.ph      = ph;
    p.tick    = tick;
    p.bit_idx = bit_idx;
    p.level   = level;
    pins_q.push_back(p);
  endtask

  // Stops offering words and waits until every predicted result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic set_thresholds(logic [12:0] line_low, logic [12:0] short_lvl,
                                logic [12:0] over_lvl);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_LINE_LOW;
    cfg_wdata <= line_low;
    @(posedge clk);
    th_line_low = line_low;
    cfg_addr  <= CFG_SHORT;
    cfg_wdata <= short_lvl;
    @(posedge clk);
    th_short = short_lvl;
    cfg_addr  <= CFG_OVERVOLT;
    cfg_wdata <= over_lvl;
    @(posedge clk);
    th_over = over_lvl;
    cfg_we <= 1'b0;
  endtask

  task automatic test_idle_ticks();
    ow_item_t it;
    for (int i = 0; i < 4; i++) begin
      it.action  = ACT_TICK;
      it.port    = i[0];
      it.value   = i[0] ? 8'hFF : 8'h00;
      it.up_mv   = i[1] ? 13'h1FFF : 13'h0000;
      it.down_mv = i[0] ? 13'h0000 : 13'h1FFF;
      send_word(it);
    end
  endtask

  task automatic test_reset_presence();
    pins_q.delete();
    device_present = 1'b0;
    // Only one window sample below the line-low level: a device answers.
    pin_level(PH_RST_WIN, 8, 0, 13'd100);
    send_command(ACT_RESET, 1'b1, 8'($urandom));
    repeat (5) send_tick();
    send_command(ACT_BYTE, 1'b0, 8'($urandom));
    finish_command();
    // Low between samples and exactly at the level on a sample: no presence.
    pins_q.delete();
    pin_level(PH_RST_WIN, 5, 0, 13'd0);
    pin_level(PH_RST_WIN, 12, 0, th_line_low);
    send_command(ACT_RESET, 1'b0, 8'($urandom));
    finish_command();
    pins_q.delete();
    device_present = 1'b1;
  endtask

  task automatic test_write_bits();
    pins_q.delete();
    pin_level(PH_PRE_SAFE, 0, 0, th_short);
    pin_level(PH_PRE_SAFE, SAFE_SECOND_TICK, 0, th_over);
    pin_level(PH_PULL, STUCK_CHECK_TICK, 0, th_line_low);
    pin_level(PH_POST_SAFE, 0, 0, th_over);
    pin_level(PH_POST_SAFE, SAFE_SECOND_TICK, 0, th_short);
    send_command(ACT_BIT, 1'b0, 8'hFF);
    finish_command();
    pins_q.delete();
    send_command(ACT_BIT, 1'b1, 8'hFE);
    finish_command();
    send_command(ACT_BIT, 1'b1, 8'h01);
    finish_command();
  endtask

  task automatic test_write_byte();
    pins_q.delete();
    send_command(ACT_BYTE, 1'b1, 8'hA5);
    finish_command();
    // The final check of bit two fails, so the rest of the byte is dropped.
    pin_level(PH_POST_SAFE, SAFE_SECOND_TICK, 2, bad_level());
    send_command(ACT_BYTE, 1'b0, 8'h5A);
    finish_command();
    pins_q.delete();
  endtask

  task automatic test_unsafe_bus();
    pins_q.delete();
    pin_level(PH_PRE_SAFE, 0, 0, 13'd0);
    send_command(ACT_BIT, 1'b0, 8'($urandom));
    finish_command();
    pins_q.delete();
    pin_level(PH_PRE_SAFE, SAFE_SECOND_TICK, 0, 13'h1FFF);
    send_command(ACT_RESET, 1'b1, 8'($urandom));
    repeat (3) send_tick();
    send_command(ACT_BIT, 1'b0, 8'($urandom));
    finish_command();
    pins_q.delete();
    pin_level(PH_POST_SAFE, 0, 0, bad_level());
    send_command(ACT_BIT, 1'b1, 8'($urandom));
    finish_command();
    pins_q.delete();
  endtask

  task automatic test_threshold_extremes();
    pins_q.delete();
    drain();
    set_thresholds(13'h1FFF, 13'h0000, 13'h1FFF);
    send_command(ACT_BIT, 1'($urandom), 8'($urandom));
    finish_command();
    drain();
    set_thresholds(13'h0000, 13'h0000, 13'h1FFF);
    send_command(ACT_BIT, 1'($urandom), 8'($urandom));
    finish_command();
    drain();
    // The short limit above the overvoltage limit leaves no safe level.
    set_thresholds(13'h0000, 13'h1FFF, 13'h0000);
    send_command(ACT_BIT, 1'($urandom), 8'($urandom));
    finish_command();
    drain();
    set_thresholds(13'd800, 13'd1500, 13'd5500);
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    sink_hold = 1'b1;
    send_command(ACT_BIT, 1'($urandom), 8'($urandom));
    repeat (60) send_tick();
    calm = 1'b0;
    drain();
    finish_command();
    drain();
  endtask

  task automatic random_traffic(int n_words);
    int r;
    int sent;
    sent = 0;
    while (sent < n_words) begin
      calm = (sent >= n_words / 2) && (sent < n_words / 2 + 150);
      if (ow_phase == PH_IDLE) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_tick();
        end else begin
          pins_q.delete();
          device_present = 1'($urandom);
          if ($urandom_range(0, 5) == 0)
            pin_level($urandom_range(0, 1) ? PH_PRE_SAFE : PH_POST_SAFE,
                      $urandom_range(0, 1) ? SAFE_SECOND_TICK : 0,
                      $urandom_range(0, 7), bad_level());
          if (r < 72) send_command(ACT_BIT, 1'($urandom), 8'($urandom));
          else if (r < 82) send_command(ACT_BYTE, 1'($urandom), 8'($urandom));
          else if (r < 88) send_command(ACT_RESET, 1'($urandom), 8'($urandom));
          else send_command(action_t'($urandom_range(1, 3)), 1'($urandom), 8'($urandom));
        end
      end else if ($urandom_range(0, 39) == 0) begin
        send_command(action_t'($urandom_range(1, 3)), 1'($urandom), 8'($urandom));
      end else begin
        send_tick();
      end
      sent++;
    end
    calm = 1'b0;
    pins_q.delete();
  endtask

  task automatic test_random_traffic();
    int short_lvl;
    random_traffic(RANDOM_WORDS / 2);
    drain();
    short_lvl = $urandom_range(0, 3000);
    set_thresholds(13'($urandom_range(0, MV_MAX)), 13'(short_lvl),
                   13'($urandom_range(MV_MAX, short_lvl)));
    random_traffic(RANDOM_WORDS / 2);
    finish_command();
    drain();
    set_thresholds(13'd800, 13'd1500, 13'd5500);
  endtask

  // Runs last: the stuck fault stays latched for the rest of the run.
  task automatic test_stuck_fault();
    finish_command();
    pins_q.delete();
    pin_level(PH_PULL, STUCK_CHECK_TICK, 0, 13'h1FFF);
    send_command(ACT_BIT, 1'b1, 8'($urandom));
    finish_command();
    pins_q.delete();
    send_command(ACT_RESET, 1'b0, 8'($urandom));
    send_tick();
    send_command(ACT_BIT, 1'b1, 8'($urandom));
    send_command(ACT_BYTE, 1'b0, 8'($urandom));
    repeat (4) send_tick();
  endtask

  // Result sink: random stalls, plus one long hold-off when asked.
  initial begin : result_sink
    forever begin
      if (sink_hold) begin
        out_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    word_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pull_up   = out_tdata[0];
      got.pull_down = out_tdata[1];
      got.busy      = out_tdata[2];
      got.done      = out_tdata[3];
      got.status    = status_t'(out_tdata[6:4]);
      got.presence  = out_tdata[7];
      got.fault     = out_tdata[8];
      if (expected_words.size() == 0) begin
        bad_words++;
        if (bad_words <= 10) $display("ERROR: result word %h with none predicted", out_tdata);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          bad_words++;
          if (bad_words <= 10)
            $display({"ERROR: result word: expected pu=%0b pd=%0b busy=%0b done=%0b ",
                      "st=%0d pres=%0b flt=%0b, got pu=%0b pd=%0b busy=%0b done=%0b ",
                      "st=%0d pres=%0b flt=%0b"},
                     want.pull_up, want.pull_down, want.busy, want.done, want.status,
                     want.presence, want.fault, got.pull_up, got.pull_down, got.busy,
                     got.done, got.status, got.presence, got.fault);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("onewire_master_with_bus_guard_top: mismatch");
    $finish;
  end

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_reset_presence();
    test_write_bits();
    test_write_byte();
    test_unsafe_bus();
    test_threshold_extremes();
    test_backpressure();
    test_random_traffic();
    test_stuck_fault();
    drain();
    repeat (10) @(posedge clk);
    if (bad_words == 0 && expected_words.size() == 0)
      $display("onewire_master_with_bus_guard_top: match");
    else
      $display("onewire_master_with_bus_guard_top: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
sv/owmbg_pkg.sv
sv/onewire_master_with_bus_guard_top.sv
sv/owmbg_checker.sv
dv/tb_onewire_master_with_bus_guard_top.sv
